FILE: rtl/iosb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the in-order sequence buffer.
package iosb_pkg;

	// Default sizes
	localparam int IOSB_DEPTH       = 16;
	localparam int IOSB_SEQ_BITS    = 32;
	localparam int IOSB_HANDLE_BITS = 16;
	localparam int CMD_BITS         = 3;
	localparam int STATUS_BITS      = 3;

	// Command codes of an input item
	typedef enum logic [CMD_BITS-1:0] {
		CMD_INSERT   = 3'd0,
		CMD_OFFER    = 3'd1,
		CMD_TAKE     = 3'd2,
		CMD_ADV_TAKE = 3'd3,
		CMD_ADVANCE  = 3'd4,
		CMD_RESTART  = 3'd5
	} cmd_t;

	// Status codes of a result item
	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK           = 3'd0,
		ST_DUPLICATE    = 3'd1,
		ST_COLLISION    = 3'd2,
		ST_NOT_EXPECTED = 3'd3,
		ST_LEFT_OVER    = 3'd4
	} status_t;

	// Controller states
	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_MOD,
		S_PROBE,
		S_CHECK,
		S_SCAN,
		S_DRAIN,
		S_DECIDE,
		S_OUT
	} state_t;

	// Source of the staged result
	typedef enum logic [2:0] {
		RES_NONE,
		RES_PASS,
		RES_ZERO,
		RES_LEFT,
		RES_INSERT
	} res_src_t;

	// Controller to datapath
	typedef struct packed {
		logic     latch;
		logic     advance;
		logic     exp_clear;
		logic     mod_step;
		logic     probe;
		logic     check;
		logic     scan_start;
		logic     scan_step;
		logic     decide;
		res_src_t res;
		logic     out_load;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic offer_hit;
		logic mod_last;
		logic scan_last;
		logic out_free;
	} dp_stat_t;

endpackage

FILE: rtl/iosb_req_if.sv
`timescale 1ns / 1ps
// Request channel: command, sequence number and handle with valid/ready.
interface iosb_req_if import iosb_pkg::*; #(
	parameter int SEQ_BITS    = IOSB_SEQ_BITS,
	parameter int HANDLE_BITS = IOSB_HANDLE_BITS
);
	logic                   valid;
	logic                   ready;
	logic [CMD_BITS-1:0]    cmd;
	logic [SEQ_BITS-1:0]    seq_in;
	logic [HANDLE_BITS-1:0] handle_in;

	modport source (output valid, cmd, seq_in, handle_in, input ready);
	modport sink (input valid, cmd, seq_in, handle_in, output ready);
endinterface

FILE: rtl/iosb_rsp_if.sv
`timescale 1ns / 1ps
// Response channel: found flag, handle and status with valid/ready.
interface iosb_rsp_if import iosb_pkg::*; #(
	parameter int HANDLE_BITS = IOSB_HANDLE_BITS
);
	logic                   valid;
	logic                   ready;
	logic                   found;
	logic [HANDLE_BITS-1:0] handle_out;
	logic [STATUS_BITS-1:0] status;

	modport source (output valid, found, handle_out, status, input ready);
	modport sink (input valid, found, handle_out, status, output ready);
endinterface

FILE: rtl/iosb_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module iosb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: rtl/iosb_datapath.sv
`timescale 1ns / 1ps
// Datapath: slot store, valid bits, slot index unit, lowest-entry scan and result registers.
module iosb_datapath import iosb_pkg::*; #(
	parameter int DEPTH       = IOSB_DEPTH,
	parameter int SEQ_BITS    = IOSB_SEQ_BITS,
	parameter int HANDLE_BITS = IOSB_HANDLE_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  dp_cmd_t                ctrl,
	output dp_stat_t               stat,
	input  logic [SEQ_BITS-1:0]    seq_in,
	input  logic [HANDLE_BITS-1:0] handle_in,
	output logic                   rsp_valid,
	input  logic                   rsp_ready,
	output logic                   found,
	output logic [HANDLE_BITS-1:0] handle_out,
	output status_t                status
);
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CHUNK_W = 8;
	localparam int N_CODES = 1 << CHUNK_W;
	localparam int N_CHUNK = (SEQ_BITS + CHUNK_W - 1) / CHUNK_W;
	localparam int SH_W    = N_CHUNK * CHUNK_W;
	localparam int CNT_W   = $clog2(N_CHUNK + 1);
	localparam int ENT_W   = SEQ_BITS + HANDLE_BITS;
	localparam logic [IDX_W:0]   DEPTH_X  = DEPTH[IDX_W:0];
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

	// Item and counter registers
	logic [SEQ_BITS-1:0]    expected_q;
	logic [SEQ_BITS-1:0]    seq_q;
	logic [HANDLE_BITS-1:0] handle_q;
	logic [SH_W-1:0]        sh_q;
	logic [IDX_W-1:0]       rem_q;
	logic [CNT_W-1:0]       cnt_q;
	status_t                ins_st_q;
	logic [DEPTH-1:0]       valid_q;

	// Scan registers
	logic [IDX_W-1:0]       scan_idx_q;
	logic                   act_s1;
	logic                   vld_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic                   any_q;
	logic [SEQ_BITS-1:0]    best_seq_q;
	logic [HANDLE_BITS-1:0] best_handle_q;
	logic [IDX_W-1:0]       best_idx_q;

	// Result staging and output registers
	logic                   res_found_q;
	logic [HANDLE_BITS-1:0] res_handle_q;
	status_t                res_status_q;
	logic                   rsp_valid_q;
	logic                   rsp_found_q;
	logic [HANDLE_BITS-1:0] rsp_handle_q;
	status_t                rsp_status_q;

	logic [IDX_W-1:0]       fold_tab  [DEPTH];
	logic [IDX_W-1:0]       chunk_tab [N_CODES];
	logic [CHUNK_W-1:0]     chunk;
	logic [IDX_W:0]         fold_sum;
	logic [IDX_W:0]         rem_next;
	logic                   ram_we;
	logic [IDX_W-1:0]       ram_raddr;
	logic [ENT_W-1:0]       ram_rdata;
	logic [SEQ_BITS-1:0]    rd_seq;
	logic [HANDLE_BITS-1:0] rd_handle;
	logic                   slot_busy;
	status_t                ins_st;
	logic                   better;
	logic                   hit;
	status_t                take_st;

	// Entry store: sequence number over handle
	assign ram_we    = ctrl.check && !slot_busy;
	assign ram_raddr = ctrl.probe ? rem_q : scan_idx_q;

	iosb_ram #(
		.WIDTH(ENT_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(rem_q),
		.wdata({seq_q, handle_q}),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_seq    = ram_rdata[ENT_W-1:HANDLE_BITS];
	assign rd_handle = ram_rdata[HANDLE_BITS-1:0];

	// Constant tables: remainder shifted up by one byte, and byte value, both modulo DEPTH
	for (genvar g = 0; g < DEPTH; g++) begin : g_fold
		assign fold_tab[g] = IDX_W'((g * N_CODES) % DEPTH);
	end

	for (genvar g = 0; g < N_CODES; g++) begin : g_chunk
		assign chunk_tab[g] = IDX_W'(g % DEPTH);
	end

	// Slot index step: fold in one byte of the sequence number, top byte first
	always_comb begin
		chunk    = sh_q[SH_W-1 -: CHUNK_W];
		fold_sum = {1'b0, fold_tab[rem_q]} + {1'b0, chunk_tab[chunk]};
		rem_next = (fold_sum >= DEPTH_X) ? (fold_sum - DEPTH_X) : fold_sum;
	end

	// Insert check against the chosen slot
	always_comb begin
		slot_busy = valid_q[rem_q];
		if (!slot_busy) begin
			ins_st = ST_OK;
		end else if (rd_seq == seq_q) begin
			ins_st = ST_DUPLICATE;
		end else begin
			ins_st = ST_COLLISION;
		end
	end

	// Scan compare and take decision
	assign better  = act_s1 && vld_s1 && (!any_q || (rd_seq < best_seq_q));
	assign hit     = any_q && (best_seq_q == expected_q);
	assign take_st = (any_q && !hit) ? ST_NOT_EXPECTED : ST_OK;

	// Expected-next counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q <= '0;
		end else if (ctrl.exp_clear) begin
			expected_q <= '0;
		end else if (ctrl.advance) begin
			expected_q <= expected_q + SEQ_BITS'(1);
		end
	end

	// Item capture and slot index unit
	always_ff @(posedge clk) begin
		if (ctrl.latch) begin
			seq_q    <= seq_in;
			handle_q <= handle_in;
			sh_q     <= SH_W'(seq_in);
			rem_q    <= '0;
			cnt_q    <= CNT_W'(N_CHUNK - 1);
			ins_st_q <= ST_OK;
		end else begin
			if (ctrl.mod_step) begin
				sh_q  <= sh_q << CHUNK_W;
				rem_q <= rem_next[IDX_W-1:0];
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (ctrl.check) begin
				ins_st_q <= ins_st;
			end
		end
	end

	// Valid bits: set on a free-slot insert, cleared on a successful take
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (ram_we) begin
				valid_q[rem_q] <= 1'b1;
			end
			if (ctrl.decide && hit) begin
				valid_q[best_idx_q] <= 1'b0;
			end
		end
	end

	// Scan address and read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1 <= 1'b0;
			any_q  <= 1'b0;
		end else begin
			act_s1 <= ctrl.scan_step;
			if (ctrl.scan_start) begin
				any_q <= 1'b0;
			end else if (better) begin
				any_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.scan_start) begin
			scan_idx_q <= '0;
		end else if (ctrl.scan_step) begin
			scan_idx_q <= scan_idx_q + IDX_W'(1);
		end
		vld_s1 <= valid_q[scan_idx_q];
		idx_s1 <= scan_idx_q;
		if (better) begin
			best_seq_q    <= rd_seq;
			best_handle_q <= rd_handle;
			best_idx_q    <= idx_s1;
		end
	end

	// Result staging
	always_ff @(posedge clk) begin
		if (ctrl.decide) begin
			res_found_q  <= hit;
			res_handle_q <= hit ? best_handle_q : '0;
			res_status_q <= (ins_st_q != ST_OK) ? ins_st_q : take_st;
		end else begin
			case (ctrl.res)
				RES_PASS: begin
					res_found_q  <= 1'b1;
					res_handle_q <= handle_q;
					res_status_q <= ST_OK;
				end
				RES_ZERO: begin
					res_found_q  <= 1'b0;
					res_handle_q <= '0;
					res_status_q <= ST_OK;
				end
				RES_LEFT: begin
					res_found_q  <= 1'b0;
					res_handle_q <= '0;
					res_status_q <= (|valid_q) ? ST_LEFT_OVER : ST_OK;
				end
				RES_INSERT: begin
					res_found_q  <= 1'b0;
					res_handle_q <= '0;
					res_status_q <= ins_st;
				end
				default: begin
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			rsp_found_q  <= res_found_q;
			rsp_handle_q <= res_handle_q;
			rsp_status_q <= res_status_q;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign found      = rsp_found_q;
	assign handle_out = rsp_handle_q;
	assign status     = rsp_status_q;

	// Status to controller
	assign stat.offer_hit = (seq_q == expected_q);
	assign stat.mod_last  = (cnt_q == '0);
	assign stat.scan_last = (scan_idx_q == LAST_IDX);
	assign stat.out_free  = !rsp_valid_q || rsp_ready;

	// Checks
	a_insert_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> valid_q[$past(rem_q)])
		else $error("insert did not mark its slot valid");

	a_take_clears_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.decide && hit |=> !valid_q[$past(best_idx_q)])
		else $error("successful take left its slot valid");

	a_no_handle_without_found: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp_found_q |-> rsp_handle_q == '0)
		else $error("handle present on a result with nothing found");
endmodule

FILE: rtl/iosb_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine sequencing each command through the datapath.
module iosb_ctrl import iosb_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic [CMD_BITS-1:0] req_cmd,
	output logic                req_ready,
	output dp_cmd_t             ctrl,
	input  dp_stat_t            stat
);
	state_t state_q;
	state_t state_d;
	cmd_t   cmd_q;

	// State and command registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q   <= CMD_INSERT;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && req_valid) begin
				cmd_q <= cmd_t'(req_cmd);
			end
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (cmd_q == CMD_INSERT) begin
					state_d = S_MOD;
				end else if (cmd_q == CMD_OFFER) begin
					state_d = stat.offer_hit ? S_OUT : S_MOD;
				end else if (cmd_q inside {CMD_TAKE, CMD_ADV_TAKE}) begin
					state_d = S_SCAN;
				end else begin
					state_d = S_OUT;
				end
			end
			S_MOD: begin
				if (stat.mod_last) begin
					state_d = S_PROBE;
				end
			end
			S_PROBE: state_d = S_CHECK;
			S_CHECK: state_d = (cmd_q == CMD_INSERT) ? S_OUT : S_SCAN;
			S_SCAN: begin
				if (stat.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN:  state_d = S_DECIDE;
			S_DECIDE: state_d = S_OUT;
			S_OUT: begin
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Datapath commands
	always_comb begin
		ctrl      = '0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready  = 1'b1;
				ctrl.latch = req_valid;
			end
			S_DECODE: begin
				case (cmd_q)
					CMD_INSERT: begin
					end
					CMD_OFFER: begin
						if (stat.offer_hit) begin
							ctrl.res = RES_PASS;
						end
					end
					CMD_TAKE: ctrl.scan_start = 1'b1;
					CMD_ADV_TAKE: begin
						ctrl.advance    = 1'b1;
						ctrl.scan_start = 1'b1;
					end
					CMD_ADVANCE: begin
						ctrl.advance = 1'b1;
						ctrl.res     = RES_ZERO;
					end
					CMD_RESTART: begin
						ctrl.exp_clear = 1'b1;
						ctrl.res       = RES_LEFT;
					end
					default: ctrl.res = RES_ZERO;
				endcase
			end
			S_MOD:   ctrl.mod_step = 1'b1;
			S_PROBE: ctrl.probe = 1'b1;
			S_CHECK: begin
				ctrl.check = 1'b1;
				if (cmd_q == CMD_INSERT) begin
					ctrl.res = RES_INSERT;
				end else begin
					ctrl.scan_start = 1'b1;
				end
			end
			S_SCAN:   ctrl.scan_step = 1'b1;
			S_DRAIN: begin
			end
			S_DECIDE: ctrl.decide = 1'b1;
			S_OUT:    ctrl.out_load = stat.out_free;
			default: begin
			end
		endcase
	end

	// Checks
	a_scan_then_decide: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.decide |-> $past(state_q) == S_DRAIN && $past(state_q, 2) == S_SCAN)
		else $error("take decided without a complete scan");
endmodule

FILE: rtl/in_order_sequence_buffer.sv
`timescale 1ns / 1ps
// Top level of the in-order sequence buffer: controller, datapath and channel hookup.
//
//  channel | role | handshake   | payload
//  req     | sink | valid/ready | cmd, seq_in, handle_in
//  rsp     | src  | valid/ready | found, handle_out, status
//
// One item at a time; one result item per request item, in order.
// Steps per item: pass-through offer, advance, restart and unused codes go straight
// to the result; insert forms the slot index one byte per cycle, then probes and
// checks the slot; take and advance-take do one slot read per cycle from the entry RAM;
// an offer that is stored runs the insert steps and then the take scan.
// Reset clears the counter and all valid bits at once; no clearing pass.
// req ready is high only while idle. A stalled rsp holds its result; the next result
// then waits in the result staging registers until the output register is free.
module in_order_sequence_buffer import iosb_pkg::*; #(
	parameter int DEPTH       = IOSB_DEPTH,
	parameter int SEQ_BITS    = IOSB_SEQ_BITS,
	parameter int HANDLE_BITS = IOSB_HANDLE_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	iosb_req_if.sink   req,
	iosb_rsp_if.source rsp
);
	dp_cmd_t  ctrl;
	dp_stat_t stat;
	logic     ready;
	status_t  status;

	iosb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_cmd  (req.cmd),
		.req_ready(ready),
		.ctrl     (ctrl),
		.stat     (stat)
	);

	iosb_datapath #(
		.DEPTH      (DEPTH),
		.SEQ_BITS   (SEQ_BITS),
		.HANDLE_BITS(HANDLE_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.stat      (stat),
		.seq_in    (req.seq_in),
		.handle_in (req.handle_in),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.found     (rsp.found),
		.handle_out(rsp.handle_out),
		.status    (status)
	);

	assign req.ready  = ready;
	assign rsp.status = status;
endmodule

FILE: test/in_order_sequence_buffer_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the in-order sequence buffer: directed table, then random traffic.
module in_order_sequence_buffer_test;
	import iosb_pkg::*;

	localparam int DEPTH = IOSB_DEPTH;
	localparam int SEQ_W = IOSB_SEQ_BITS;
	localparam int HDL_W = IOSB_HANDLE_BITS;

	// Codes outside the command set; the block must answer them with an all-zero item
	localparam logic [CMD_BITS-1:0] CMD_SPARE_A = 3'd6;
	localparam logic [CMD_BITS-1:0] CMD_SPARE_B = 3'd7;

	localparam int RANDOM_PER_PHASE = 370;
	localparam int DRAIN_CYCLES     = 64;

	typedef struct packed {
		logic             found;
		logic [HDL_W-1:0] handle;
		status_t          status;
	} reply_t;

	typedef struct {
		logic [CMD_BITS-1:0] op;
		logic [SEQ_W-1:0]    seq;
		logic [HDL_W-1:0]    hdl;
		bit                  typed;
		reply_t              want;
	} plan_row_t;

	localparam reply_t QUIET = '{found: 1'b0, handle: '0, status: ST_OK};

	logic clk;
	logic arst_n;

	iosb_req_if req_ch ();
	iosb_rsp_if rsp_ch ();

	in_order_sequence_buffer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the buffer contents and the next-expected counter
	logic             slot_used [DEPTH];
	logic [SEQ_W-1:0] slot_tag  [DEPTH];
	logic [HDL_W-1:0] slot_hdl  [DEPTH];
	logic [SEQ_W-1:0] next_seq;

	reply_t awaited_replies [$];
	reply_t head_reply;
	int     fault_count = 0;
	int     sender_idle_pct = 0;
	int     sink_stall_pct  = 0;

	// Directed items: result typed in where it is obvious, otherwise left to the predictor
	plan_row_t directed_plan [24] = '{
		'{CMD_TAKE,     32'h0000_0000, 16'h0000, 1'b1, '{1'b0, 16'h0000, ST_OK}},
		'{CMD_RESTART,  32'h0000_0000, 16'h0000, 1'b1, '{1'b0, 16'h0000, ST_OK}},
		'{CMD_INSERT,   32'h0000_0002, 16'hFFFF, 1'b1, '{1'b0, 16'h0000, ST_OK}},
		'{CMD_INSERT,   32'h0000_0002, 16'h1234, 1'b1, '{1'b0, 16'h0000, ST_DUPLICATE}},
		'{CMD_INSERT,   32'h0000_0012, 16'h1234, 1'b1, '{1'b0, 16'h0000, ST_COLLISION}},
		'{CMD_INSERT,   32'hFFFF_FFF2, 16'h0000, 1'b1, '{1'b0, 16'h0000, ST_COLLISION}},
		'{CMD_TAKE,     32'hFFFF_FFFF, 16'hFFFF, 1'b1, '{1'b0, 16'h0000, ST_NOT_EXPECTED}},
		'{CMD_OFFER,    32'h0000_0000, 16'hABCD, 1'b1, '{1'b1, 16'hABCD, ST_OK}},
		'{CMD_OFFER,    32'h0000_0001, 16'h0001, 1'b0, QUIET},
		'{CMD_ADV_TAKE, 32'h0000_0000, 16'h0000, 1'b0, QUIET},
		'{CMD_ADV_TAKE, 32'h0000_0000, 16'h0000, 1'b0, QUIET},
		'{CMD_ADV_TAKE, 32'h0000_0000, 16'h0000, 1'b0, QUIET},
		'{CMD_OFFER,    32'h0000_0003, 16'h0000, 1'b0, QUIET},
		'{CMD_INSERT,   32'h0000_0004, 16'h5555, 1'b0, QUIET},
		'{CMD_ADVANCE,  32'h0000_0000, 16'h0000, 1'b1, '{1'b0, 16'h0000, ST_OK}},
		'{CMD_OFFER,    32'h0000_0005, 16'hAAAA, 1'b0, QUIET},
		'{CMD_OFFER,    32'hFFFF_FFF5, 16'hFFFF, 1'b0, QUIET},
		'{CMD_OFFER,    32'h0000_0005, 16'h0000, 1'b0, QUIET},
		'{CMD_RESTART,  32'h0000_0000, 16'h0000, 1'b1, '{1'b0, 16'h0000, ST_LEFT_OVER}},
		'{CMD_SPARE_A,  32'hFFFF_FFFF, 16'hFFFF, 1'b1, '{1'b0, 16'h0000, ST_OK}},
		'{CMD_SPARE_B,  32'hFFFF_FFFF, 16'hFFFF, 1'b1, '{1'b0, 16'h0000, ST_OK}},
		'{CMD_INSERT,   32'h0000_0000, 16'h0F0F, 1'b0, QUIET},
		'{CMD_TAKE,     32'h0000_0000, 16'h0000, 1'b0, QUIET},
		'{CMD_OFFER,    32'h0000_0000, 16'hFFFF, 1'b0, QUIET}
	};

	// Idle percentages of sender and receiver for each phase
	int idle_by_phase  [3] = '{16, 50, 0};
	int stall_by_phase [3] = '{50, 16, 0};

	// Clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Store an item in its slot unless the slot is taken
	function automatic status_t store_entry(logic [SEQ_W-1:0] seq, logic [HDL_W-1:0] hdl);
		int idx;
		idx = int'(seq % DEPTH);
		if (slot_used[idx])
			return (slot_tag[idx] == seq) ? ST_DUPLICATE : ST_COLLISION;
		slot_used[idx] = 1'b1;
		slot_tag[idx]  = seq;
		slot_hdl[idx]  = hdl;
		return ST_OK;
	endfunction

	// Hand back the lowest stored item if it is the one expected next
	function automatic status_t take_lowest(output logic got, output logic [HDL_W-1:0] hdl);
		int best;
		best = -1;
		got  = 1'b0;
		hdl  = '0;
		for (int i = 0; i < DEPTH; i++)
			if (slot_used[i] && (best < 0 || slot_tag[i] < slot_tag[best]))
				best = i;
		if (best < 0)
			return ST_OK;
		if (slot_tag[best] != next_seq)
			return ST_NOT_EXPECTED;
		got             = 1'b1;
		hdl             = slot_hdl[best];
		slot_used[best] = 1'b0;
		return ST_OK;
	endfunction

	// Apply one command to the shadow state and return the reply it should give
	function automatic reply_t predict_reply(logic [CMD_BITS-1:0] op, logic [SEQ_W-1:0] seq,
			logic [HDL_W-1:0] hdl);
		reply_t  res;
		status_t st_store;
		status_t st_take;
		res = QUIET;
		case (op)
			CMD_INSERT: res.status = store_entry(seq, hdl);
			CMD_OFFER: begin
				if (seq == next_seq) begin
					res.found  = 1'b1;
					res.handle = hdl;
				end else begin
					st_store   = store_entry(seq, hdl);
					st_take    = take_lowest(res.found, res.handle);
					res.status = (st_store != ST_OK) ? st_store : st_take;
				end
			end
			CMD_TAKE: res.status = take_lowest(res.found, res.handle);
			CMD_ADV_TAKE: begin
				next_seq   = next_seq + 1'b1;
				res.status = take_lowest(res.found, res.handle);
			end
			CMD_ADVANCE: next_seq = next_seq + 1'b1;
			CMD_RESTART: begin
				next_seq = '0;
				for (int i = 0; i < DEPTH; i++)
					if (slot_used[i])
						res.status = ST_LEFT_OVER;
			end
			default: ;
		endcase
		return res;
	endfunction

	// Pick the next random item; mostly in-window traffic, some clashes and broken sequences
	task automatic choose_request(output logic [CMD_BITS-1:0] op, output logic [SEQ_W-1:0] seq,
			output logic [HDL_W-1:0] hdl);
		int               roll;
		int               slot;
		int               head_idx;
		bit               any;
		bit               stale;
		bit               head_held;
		logic [SEQ_W-1:0] low_tag;
		any     = 1'b0;
		low_tag = '1;
		for (int i = 0; i < DEPTH; i++)
			if (slot_used[i]) begin
				any = 1'b1;
				if (slot_tag[i] < low_tag)
					low_tag = slot_tag[i];
			end
		stale     = any && (low_tag < next_seq);
		head_idx  = int'(next_seq % DEPTH);
		head_held = slot_used[head_idx] && (slot_tag[head_idx] == next_seq);
		slot      = $urandom_range(0, DEPTH - 1);
		roll      = $urandom_range(0, 99);
		op        = CMD_TAKE;
		seq       = $urandom;
		hdl       = HDL_W'($urandom);
		// an entry below the counter blocks every take until a restart
		if (stale && roll < 50)
			op = CMD_RESTART;
		else if (!any && next_seq > 48)
			op = CMD_RESTART;
		// entries far ahead: walk the counter up to them
		else if (any && low_tag > next_seq + DEPTH && roll < 60)
			op = CMD_ADVANCE;
		else if (roll < 35) begin
			op  = CMD_OFFER;
			seq = next_seq + $urandom_range(0, DEPTH - 1);
		end else if (roll < 55) begin
			op  = CMD_INSERT;
			seq = next_seq + $urandom_range(0, DEPTH - 1);
		end else if (roll < 65)
			op = CMD_TAKE;
		else if (roll < 80)
			op = head_held ? CMD_TAKE : CMD_ADV_TAKE;
		else if (roll < 85)
			op = CMD_ADVANCE;
		else if (roll < 93) begin
			// clash with or repeat an occupied slot; never stores a stray number
			if (slot_used[slot]) begin
				op  = ($urandom_range(0, 1) != 0) ? CMD_INSERT : CMD_OFFER;
				seq = (roll < 90) ? seq - (seq % DEPTH) + slot : slot_tag[slot];
			end
		end else if (roll < 95) begin
			if (next_seq >= 4) begin
				op  = CMD_INSERT;
				seq = next_seq - $urandom_range(1, 4);
			end
		end else if (roll < 97)
			op = CMD_RESTART;
		else
			op = ($urandom_range(0, 1) != 0) ? CMD_SPARE_A : CMD_SPARE_B;
	endtask

	// Present one item, wait for acceptance and queue its expected reply
	task automatic send_request(input logic [CMD_BITS-1:0] op, input logic [SEQ_W-1:0] seq,
			input logic [HDL_W-1:0] hdl, input bit typed, input reply_t typed_reply);
		reply_t model_reply;
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.cmd       <= op;
		req_ch.seq_in    <= seq;
		req_ch.handle_in <= hdl;
		do
			@(posedge clk);
		while (!req_ch.ready);
		model_reply = predict_reply(op, seq, hdl);
		awaited_replies.push_back(typed ? typed_reply : model_reply);
		@(negedge clk);
	endtask

	// Receiver back-pressure
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
		end
	end

	// Compare each reply item with the oldest one awaited
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (awaited_replies.size() == 0) begin
				$error("reply with none awaited: found %0b handle %h status %0d",
					rsp_ch.found, rsp_ch.handle_out, rsp_ch.status);
				fault_count++;
			end else begin
				head_reply = awaited_replies.pop_front();
				if (rsp_ch.found !== head_reply.found) begin
					$error("found: expected %0b, got %0b", head_reply.found, rsp_ch.found);
					fault_count++;
				end
				if (rsp_ch.handle_out !== head_reply.handle) begin
					$error("handle_out: expected %h, got %h", head_reply.handle,
						rsp_ch.handle_out);
					fault_count++;
				end
				if (rsp_ch.status !== head_reply.status) begin
					$error("status: expected %0d, got %0d", head_reply.status, rsp_ch.status);
					fault_count++;
				end
			end
		end
	end

	// Stimulus
	initial begin : stimulus
		logic [CMD_BITS-1:0] op;
		logic [SEQ_W-1:0]    seq;
		logic [HDL_W-1:0]    hdl;
		int                  counted;
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.cmd       = CMD_INSERT;
		req_ch.seq_in    = '0;
		req_ch.handle_in = '0;
		next_seq         = '0;
		for (int i = 0; i < DEPTH; i++) begin
			slot_used[i] = 1'b0;
			slot_tag[i]  = '0;
			slot_hdl[i]  = '0;
		end
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int phase = 0; phase < 3; phase++) begin
			sender_idle_pct = idle_by_phase[phase];
			sink_stall_pct  = stall_by_phase[phase];
			if (phase == 0)
				foreach (directed_plan[i])
					send_request(directed_plan[i].op, directed_plan[i].seq, directed_plan[i].hdl,
						directed_plan[i].typed, directed_plan[i].want);
			counted = 0;
			while (counted < RANDOM_PER_PHASE) begin
				choose_request(op, seq, hdl);
				send_request(op, seq, hdl, 1'b0, QUIET);
				if (op != CMD_SPARE_A && op != CMD_SPARE_B)
					counted++;
			end
		end
		req_ch.valid <= 1'b0;

		// Let the last replies arrive, then watch for strays
		while (awaited_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog
	initial begin
		#(10ms);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
